>>> src/slr_pkg.sv
// Shared types and constants for the stereo linear resampler.
// Used by the top level and the port checker; no dependencies.
package slr_pkg;

    localparam int STEP_W = 20;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

    // Register index, taken from paddr[ADDR_W-1:2].
    localparam logic [ADDR_W-3:0] REG_STEP = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_EMIT,
        ST_PASS
    } state_t;

endpackage

>>> src/slr_mul_unit.sv
// Shared multiply-add unit of the stereo linear resampler.
// Registers difference times phase fraction, then adds the scaled product to a base sample.
// Depends on nothing but its parameters.
module slr_mul_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          mul_en,
    input  logic signed [SAMPLE_BITS:0]   diff,
    input  logic        [FRAC_BITS-1:0]   frac,
    input  logic        [SAMPLE_BITS-1:0] base,
    output logic        [SAMPLE_BITS-1:0] result
);

    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // An arithmetic shift by FRAC_BITS floors the product; the low bits of the sum are exact.
    assign result = base + prod_reg[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];

endmodule

>>> src/stereo_linear_resampler.sv
// Top level of the stereo linear resampler: sequencer, state, output register, APB register.
// Depends on slr_pkg and slr_mul_unit.
//
// Input frames arrive on the s_axis stream, left sample in the low half of tdata.
// Interpolated frames leave on the m_axis stream; tlast marks the final frame
// produced by one input frame. The phase register steps by step_ratio (Q4.FRAC_BITS)
// per output frame; a step of one passes frames straight through.
// The step register sits at address 0 of the APB port; writing it clears the
// previous frame and the phase. Write it only while the block is idle.
// An input frame that produces no output (first frame, skipped frame) is handled in the idle state.
// A pass-through frame goes through the pass state. An interpolating frame runs the
// multiply-left, multiply-right and emit states for each output frame, at most MAX_UPSAMPLE
// outputs, because one multiplier serves the left and then the right channel of each output.
// s_axis_tready is high only while the sequencer is idle.
// The output register holds a frame until it is taken; a stalled receiver stops the
// sequencer before the next load, and the next input is accepted while the last
// frame of a run still waits. Reset clears the sequencer, the output valid, the state
// and sets the step to pass-through.
module stereo_linear_resampler #(
    parameter int MAX_UPSAMPLE = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: left_sample, right_sample.
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: left_out, right_out.
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slr_pkg::ADDR_W-1:0]     paddr,
    input  logic [slr_pkg::DATA_W-1:0]     pwdata,
    output logic [slr_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    import slr_pkg::*;

    localparam int TD_W  = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int PH_W  = FRAC_BITS + 4;
    localparam int SUM_W = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
    localparam int CNT_W = (MAX_UPSAMPLE > 1) ? $clog2(MAX_UPSAMPLE) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_UPSAMPLE - 1);
    localparam logic [SUM_W-1:0] ONE_SUM  = SUM_W'(1) << FRAC_BITS;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]      step_reg;
    logic [PH_W-1:0]        ph_reg, ph_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   have_reg, have_next;
    logic [SAMPLE_BITS-1:0] prev_l_reg, prev_l_next;
    logic [SAMPLE_BITS-1:0] prev_r_reg, prev_r_next;
    logic [SAMPLE_BITS-1:0] cur_l_reg, cur_l_next;
    logic [SAMPLE_BITS-1:0] cur_r_reg, cur_r_next;
    logic [SAMPLE_BITS-1:0] left_res_reg, left_res_next;
    logic [SAMPLE_BITS-1:0] out_l_reg, out_l_next;
    logic [SAMPLE_BITS-1:0] out_r_reg, out_r_next;
    logic                   out_last_reg, out_last_next;
    logic                   m_valid_reg, m_valid_next;

    logic                   in_xfer;
    logic                   out_free;
    logic                   cfg_step_wr;
    logic [SUM_W-1:0]       ph_ext;
    logic [SUM_W-1:0]       step_ext;
    logic [SUM_W-1:0]       ph_sum;
    logic                   step_is_one;
    logic                   ph_ge_one;
    logic                   sum_ge_one;
    logic                   emit_last;
    logic                   mul_en;
    logic signed [SAMPLE_BITS:0] diff_l, diff_r, mul_diff;
    logic [SAMPLE_BITS-1:0] mul_base;
    logic [SAMPLE_BITS-1:0] mul_result;
    logic [SAMPLE_BITS-1:0] in_l, in_r;

    assign in_l = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_r = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign pready      = 1'b1;
    assign cfg_step_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_STEP);
    assign prdata      = (paddr[ADDR_W-1:2] == REG_STEP) ? DATA_W'(step_reg) : '0;

    assign ph_ext      = SUM_W'(ph_reg);
    assign step_ext    = SUM_W'(step_reg);
    assign ph_sum      = ph_ext + step_ext;
    assign step_is_one = (step_ext == ONE_SUM);
    assign ph_ge_one   = (ph_ext >= ONE_SUM);
    assign sum_ge_one  = (ph_sum >= ONE_SUM);
    assign emit_last   = sum_ge_one || (cnt_reg == LAST_CNT);

    assign diff_l   = $signed({cur_l_reg[SAMPLE_BITS-1], cur_l_reg})
                    - $signed({prev_l_reg[SAMPLE_BITS-1], prev_l_reg});
    assign diff_r   = $signed({cur_r_reg[SAMPLE_BITS-1], cur_r_reg})
                    - $signed({prev_r_reg[SAMPLE_BITS-1], prev_r_reg});
    assign mul_en   = (state_reg == ST_MUL_L) || (state_reg == ST_MUL_R);
    assign mul_diff = (state_reg == ST_MUL_L) ? diff_l : diff_r;
    assign mul_base = (state_reg == ST_MUL_R) ? prev_l_reg : prev_r_reg;

    slr_mul_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mul (
        .aclk   (aclk),
        .mul_en (mul_en),
        .diff   (mul_diff),
        .frac   (ph_reg[FRAC_BITS-1:0]),
        .base   (mul_base),
        .result (mul_result)
    );

    always_comb begin
        state_next    = state_reg;
        ph_next       = ph_reg;
        cnt_next      = cnt_reg;
        have_next     = have_reg;
        prev_l_next   = prev_l_reg;
        prev_r_next   = prev_r_reg;
        cur_l_next    = cur_l_reg;
        cur_r_next    = cur_r_reg;
        left_res_next = left_res_reg;
        out_l_next    = out_l_reg;
        out_r_next    = out_r_reg;
        out_last_next = out_last_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cur_l_next = in_l;
                    cur_r_next = in_r;
                    if (step_is_one) begin
                        state_next = ST_PASS;
                    end else if (!have_reg) begin
                        prev_l_next = in_l;
                        prev_r_next = in_r;
                        have_next   = 1'b1;
                    end else if (ph_ge_one) begin
                        ph_next     = PH_W'(ph_ext - ONE_SUM);
                        prev_l_next = in_l;
                        prev_r_next = in_r;
                    end else begin
                        cnt_next   = '0;
                        state_next = ST_MUL_L;
                    end
                end
            end
            ST_MUL_L: begin
                state_next = ST_MUL_R;
            end
            ST_MUL_R: begin
                left_res_next = mul_result;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_l_next    = left_res_reg;
                    out_r_next    = mul_result;
                    out_last_next = emit_last;
                    m_valid_next  = 1'b1;
                    if (emit_last) begin
                        ph_next     = sum_ge_one ? PH_W'(ph_sum - ONE_SUM) : '0;
                        prev_l_next = cur_l_reg;
                        prev_r_next = cur_r_reg;
                        state_next  = ST_IDLE;
                    end else begin
                        ph_next    = PH_W'(ph_sum);
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_MUL_L;
                    end
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    out_l_next    = cur_l_reg;
                    out_r_next    = cur_r_reg;
                    out_last_next = 1'b1;
                    m_valid_next  = 1'b1;
                    prev_l_next   = cur_l_reg;
                    prev_r_next   = cur_r_reg;
                    have_next     = 1'b1;
                    ph_next       = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_step_wr) begin
            ph_next     = '0;
            have_next   = 1'b0;
            prev_l_next = '0;
            prev_r_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_RESET;
            ph_reg      <= '0;
            have_reg    <= 1'b0;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            have_reg    <= have_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            m_valid_reg <= m_valid_next;
            if (cfg_step_wr) begin
                step_reg <= pwdata[STEP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        cur_l_reg    <= cur_l_next;
        cur_r_reg    <= cur_r_next;
        left_res_reg <= left_res_next;
        out_l_reg    <= out_l_next;
        out_r_reg    <= out_r_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TD_W'({out_r_reg, out_l_reg});
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> src/slr_checker.sv
// Port-level checker for the stereo linear resampler, bound to the top level.
// Depends on slr_pkg and on stereo_linear_resampler.
module slr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input logic                                 m_axis_tlast,
    input logic                                 pready
);

    import slr_pkg::*;

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled output frame holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // A frame that is not the last of its run means the run is still in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a run");

    // After a transfer that is not the last of its run, the input opens only once the
    // last frame of the run has been loaded in its place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !s_axis_tready || (m_axis_tvalid && m_axis_tlast))
        else $error("run ended without a last frame");

    assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind stereo_linear_resampler slr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_slr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
